// File: rtl/akmn_pkg.sv
// ----------------------------------------------------------------------------
// akmn_pkg: shared definitions for the analog keypad menu navigator
// Field widths, button ladder levels, event and button codes, config indexes.
// ----------------------------------------------------------------------------
package akmn_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int LEVEL_W   = 7;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int EVT_W     = 4;
    localparam int FUNC_W    = 4;
    localparam int SLOT_W    = 2;
    localparam int MATCH_W   = LEVEL_W + 1;

    localparam int MAX_MENU_ENTRIES = 16;
    localparam int MENU_CAP = (MAX_MENU_ENTRIES < 16) ? MAX_MENU_ENTRIES : 16;
    localparam int CURSOR_SLOTS_DEF = 4;

    localparam logic [CFG_W-1:0] MENU_ENTRIES_RST = 5'd1;
    localparam logic [CFG_W-1:0] SLOP_WINDOW_RST  = 5'd4;

    localparam int BUTTONS = 6;
    // Ladder levels in match priority order.
    localparam logic [MATCH_W-1:0] BUTTON_LEVEL [BUTTONS] =
        '{8'd20, 8'd86, 8'd42, 8'd104, 8'd63, 8'd127};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MENU_ENTRIES = 2'd0,
        CFG_SLOP_WINDOW  = 2'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        BTN_NONE         = 3'd0,
        BTN_FUNC_NEXT    = 3'd1,
        BTN_FUNC_PREV    = 3'd2,
        BTN_CURSOR_RIGHT = 3'd3,
        BTN_CURSOR_LEFT  = 3'd4,
        BTN_VALUE_UP     = 3'd5,
        BTN_VALUE_DOWN   = 3'd6
    } btn_t;

    typedef enum logic [EVT_W-1:0] {
        EV_NONE         = 4'd0,
        EV_SETTLE       = 4'd1,
        EV_HELD         = 4'd2,
        EV_FUNC_NEXT    = 4'd3,
        EV_FUNC_PREV    = 4'd4,
        EV_CURSOR_RIGHT = 4'd5,
        EV_CURSOR_LEFT  = 4'd6,
        EV_VALUE_UP     = 4'd7,
        EV_VALUE_DOWN   = 4'd8
    } evt_t;

    typedef struct packed {
        logic settle;
        btn_t button;
    } dec_t;

endpackage

// File: rtl/akmn_if.sv
// ----------------------------------------------------------------------------
// akmn_if: valid/ready channels of the keypad navigator
// Sample channel in, result channel out; a transfer needs valid and ready.
// ----------------------------------------------------------------------------
interface akmn_sample_if;
    logic                        valid;
    logic                        ready;
    logic [akmn_pkg::SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface akmn_result_if;
    logic                       valid;
    logic                       ready;
    logic [akmn_pkg::EVT_W-1:0]  event_res;
    logic [akmn_pkg::FUNC_W-1:0] function_index;
    logic [akmn_pkg::SLOT_W-1:0] cursor_slot;

    modport source (output valid, output event_res, output function_index,
                    output cursor_slot, input ready);
    modport sink   (input valid, input event_res, input function_index,
                    input cursor_slot, output ready);
endinterface

// File: rtl/akmn_cfg.sv
// ----------------------------------------------------------------------------
// akmn_cfg: configuration registers
// Holds menu size and slop window; derives the last valid menu index.
// ----------------------------------------------------------------------------
module akmn_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [akmn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [akmn_pkg::CFG_W-1:0]     cfg_data,
    output logic [akmn_pkg::FUNC_W-1:0]    menu_last,
    output logic [akmn_pkg::CFG_W-1:0]     slop_window
);
    import akmn_pkg::*;

    logic [CFG_W-1:0] menu_entries_reg;
    logic [CFG_W-1:0] slop_window_reg;
    logic [CFG_W-1:0] menu_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            menu_entries_reg <= MENU_ENTRIES_RST;
            slop_window_reg  <= SLOP_WINDOW_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_MENU_ENTRIES)
            begin
                menu_entries_reg <= cfg_data;
            end
            else if (cfg_index == CFG_SLOP_WINDOW)
            begin
                slop_window_reg <= cfg_data;
            end
        end
    end

    // An empty menu acts as one entry; larger menus are clamped.
    always_comb
    begin
        menu_size = menu_entries_reg;
        if (menu_size == '0)
        begin
            menu_size = CFG_W'(1);
        end
        if (menu_size > CFG_W'(MENU_CAP))
        begin
            menu_size = CFG_W'(MENU_CAP);
        end
    end

    assign menu_last   = FUNC_W'(menu_size - CFG_W'(1));
    assign slop_window = slop_window_reg;

    property p_size_in_range;
        @(posedge clk) disable iff (!rst_n)
        (menu_size != '0) && (menu_size <= CFG_W'(MENU_CAP));
    endproperty
    a_size_in_range: assert property (p_size_in_range)
        else $error("menu size out of range");

endmodule

// File: rtl/akmn_decode.sv
// ----------------------------------------------------------------------------
// akmn_decode: level stability check and button window match
// Compares the halved sample with the kept level and the six ladder levels.
// ----------------------------------------------------------------------------
module akmn_decode (
    input  logic [akmn_pkg::LEVEL_W-1:0] level,
    input  logic [akmn_pkg::LEVEL_W-1:0] stable_level,
    input  logic [akmn_pkg::CFG_W-1:0]   slop_window,
    output akmn_pkg::dec_t               dec
);
    import akmn_pkg::*;

    logic [LEVEL_W-1:0] diff;
    logic [MATCH_W-1:0] lvl_ext;
    logic [MATCH_W-1:0] slop_ext;
    logic [BUTTONS-1:0] hit;
    btn_t               button;

    assign diff = (level > stable_level) ? (level - stable_level) : (stable_level - level);
    assign lvl_ext  = MATCH_W'(level);
    assign slop_ext = MATCH_W'(slop_window);

    // b - slop < v < b + slop, rearranged to stay unsigned.
    always_comb
    begin
        for (int k = 0; k < BUTTONS; k++)
        begin
            hit[k] = (lvl_ext < (BUTTON_LEVEL[k] + slop_ext)) &&
                     ((lvl_ext + slop_ext) > BUTTON_LEVEL[k]);
        end
    end

    // Walking down from the last button leaves the first hit in place.
    always_comb
    begin
        button = BTN_NONE;
        for (int k = BUTTONS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                button = btn_t'(3'(k + 1));
            end
        end
    end

    assign dec.settle = (diff > LEVEL_W'(slop_window));
    assign dec.button = button;

endmodule

// File: rtl/akmn_nav.sv
// ----------------------------------------------------------------------------
// akmn_nav: navigation state and result register
// Updates level, held button, function and cursor; presents the result.
// ----------------------------------------------------------------------------
module akmn_nav #(
    parameter int CURSOR_SLOTS = akmn_pkg::CURSOR_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic [akmn_pkg::LEVEL_W-1:0] item_level,
    input  logic [akmn_pkg::FUNC_W-1:0]  menu_last,
    input  logic [akmn_pkg::CFG_W-1:0]   slop_window,
    output logic                        take,
    akmn_result_if.source               result
);
    import akmn_pkg::*;

    localparam int CW = $clog2(CURSOR_SLOTS);
    localparam int EW = (CW > SLOT_W) ? CW : SLOT_W;

    logic [LEVEL_W-1:0] stable_level_reg, stable_level_next;
    btn_t               held_reg, held_next;
    logic [FUNC_W-1:0]  function_reg, function_next;
    logic [CW-1:0]      cursor_reg, cursor_next;
    evt_t               evt_reg, evt_next;
    logic               out_valid_reg;
    logic               step;
    dec_t               dec;
    logic [EW-1:0]      cursor_ext;

    akmn_decode u_decode (
        .level        (item_level),
        .stable_level (stable_level_reg),
        .slop_window  (slop_window),
        .dec          (dec)
    );

    assign take = !out_valid_reg || result.ready;
    assign step = item_valid && take;

    always_comb
    begin
        stable_level_next = stable_level_reg;
        held_next         = held_reg;
        function_next     = function_reg;
        cursor_next       = cursor_reg;
        evt_next          = EV_NONE;
        if (dec.settle)
        begin
            stable_level_next = item_level;
            evt_next          = EV_SETTLE;
        end
        else if (dec.button == BTN_NONE)
        begin
            held_next = BTN_NONE;
        end
        else if (dec.button == held_reg)
        begin
            evt_next = EV_HELD;
        end
        else
        begin
            held_next = dec.button;
            unique case (dec.button)
                BTN_FUNC_NEXT:
                begin
                    evt_next      = EV_FUNC_NEXT;
                    function_next = (function_reg >= menu_last) ? '0 : function_reg + 1'b1;
                end
                BTN_FUNC_PREV:
                begin
                    evt_next = EV_FUNC_PREV;
                    if ((function_reg == '0) || (function_reg > menu_last))
                    begin
                        function_next = menu_last;
                    end
                    else
                    begin
                        function_next = function_reg - 1'b1;
                    end
                end
                BTN_CURSOR_RIGHT:
                begin
                    evt_next    = EV_CURSOR_RIGHT;
                    cursor_next = (cursor_reg == CW'(CURSOR_SLOTS - 1)) ? '0 : cursor_reg + 1'b1;
                end
                BTN_CURSOR_LEFT:
                begin
                    evt_next = EV_CURSOR_LEFT;
                    if (cursor_reg != '0)
                    begin
                        cursor_next = cursor_reg - 1'b1;
                    end
                end
                BTN_VALUE_UP:   evt_next = EV_VALUE_UP;
                BTN_VALUE_DOWN: evt_next = EV_VALUE_DOWN;
                default:        evt_next = EV_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_level_reg <= '0;
            held_reg         <= BTN_NONE;
            function_reg     <= '0;
            cursor_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                stable_level_reg <= stable_level_next;
                held_reg         <= held_next;
                function_reg     <= function_next;
                cursor_reg       <= cursor_next;
            end
            if (take)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            evt_reg <= evt_next;
        end
    end

    // State only moves on a step, so it still matches the pending result.
    assign cursor_ext            = EW'(cursor_reg);
    assign result.valid          = out_valid_reg;
    assign result.event_res      = evt_reg;
    assign result.function_index = function_reg;
    assign result.cursor_slot    = cursor_ext[SLOT_W-1:0];

    property p_cursor_range;
        @(posedge clk) disable iff (!rst_n)
        cursor_reg <= CW'(CURSOR_SLOTS - 1);
    endproperty
    a_cursor_range: assert property (p_cursor_range)
        else $error("cursor beyond last slot");

    property p_settle_keeps_level;
        @(posedge clk) disable iff (!rst_n)
        (step && dec.settle) |=> (stable_level_reg == $past(item_level)) &&
                                 (result.event_res == EV_SETTLE);
    endproperty
    a_settle_keeps_level: assert property (p_settle_keeps_level)
        else $error("settling did not store the new level");

    property p_repeat_is_quiet;
        @(posedge clk) disable iff (!rst_n)
        (step && !dec.settle && (dec.button != BTN_NONE) && (dec.button == held_reg))
            |=> (result.event_res == EV_HELD) && $stable(function_reg) && $stable(cursor_reg);
    endproperty
    a_repeat_is_quiet: assert property (p_repeat_is_quiet)
        else $error("held button repeat changed navigation state");

    property p_stall_holds_state;
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> $stable(function_reg) && $stable(held_reg)
                                             && $stable(stable_level_reg);
    endproperty
    a_stall_holds_state: assert property (p_stall_holds_state)
        else $error("state moved while result stalled");

endmodule

// File: rtl/analog_keypad_menu_navigator.sv
// ----------------------------------------------------------------------------
// analog_keypad_menu_navigator: resistor ladder keypad decoder and menu cursor
// A sample enters the sample register, then its result the result register.
// Throughput: one sample per cycle; the sample register advances whenever the
// result register is empty or being read out in the same cycle.
// Reset: level, held button, function and cursor clear to zero; the menu size
// resets to 1 and the slop window to 4. No pending sample or result remains.
// ----------------------------------------------------------------------------
module analog_keypad_menu_navigator #(
    parameter int CURSOR_SLOTS = akmn_pkg::CURSOR_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [akmn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [akmn_pkg::CFG_W-1:0]     cfg_data,
    akmn_sample_if.sink                   sample_ch,
    akmn_result_if.source                 result_ch
);
    import akmn_pkg::*;

    logic               s1_valid_reg;
    logic [LEVEL_W-1:0] s1_level_reg;
    logic               take;
    logic [FUNC_W-1:0]  menu_last;
    logic [CFG_W-1:0]   slop_window;

    akmn_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .menu_last   (menu_last),
        .slop_window (slop_window)
    );

    assign sample_ch.ready = !s1_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_ch.ready)
        begin
            s1_valid_reg <= sample_ch.valid;
        end
    end

    // The ladder is read at half resolution.
    always_ff @(posedge clk)
    begin
        if (sample_ch.ready && sample_ch.valid)
        begin
            s1_level_reg <= sample_ch.adc_sample[SAMPLE_W-1:1];
        end
    end

    akmn_nav #(
        .CURSOR_SLOTS (CURSOR_SLOTS)
    ) u_nav (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s1_valid_reg),
        .item_level  (s1_level_reg),
        .menu_last   (menu_last),
        .slop_window (slop_window),
        .take        (take),
        .result      (result_ch)
    );

endmodule
